// ===== src/ped_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character constants and hex helpers for the percent-escape decoder.
package ped_pkg;

    // Character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_F    = 8'h46;
    localparam logic [3:0] TEN        = 4'd10;

    // Most results one request can produce
    localparam int unsigned MAX_RES   = 3;

    // Escape tracking, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,   // nothing pending
        PH_PCT  = 3'b010,   // percent sign held
        PH_DIG  = 3'b100    // percent sign and one hex digit held
    } phase_t;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] res_cnt_t;

    // Uppercase hex digit test
    function automatic logic is_hex(input byte_t c);
        return ((c >= DIGIT_0) && (c <= DIGIT_9)) || ((c >= UPPER_A) && (c <= UPPER_F));
    endfunction

    // Nibble value of a hex digit (zero for anything else)
    function automatic logic [3:0] hex_nibble(input byte_t c);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if ((c >= DIGIT_0) && (c <= DIGIT_9))
            begin
                diff = c - DIGIT_0;
            end
            else if ((c >= UPPER_A) && (c <= UPPER_F))
            begin
                diff = c - UPPER_A + {4'd0, TEN};
            end
            return diff[3:0];
        end
    endfunction

endpackage

// ===== src/percent_escape_decoder_unit.sv =====
`timescale 1ns / 1ps
// Streaming percent-escape decoder: input register, decode logic, result group register.
//
// Usage:
//   Request channel (req_valid/req_ready) takes one text byte (char_in) and its
//   end_of_text flag per accepted request. Result channel (res_valid/res_ready)
//   returns bytes one at a time (char_out), final_out marking the last byte of
//   a string. "%XY" with uppercase hex digits becomes one byte; anything else
//   passes through, and incomplete escapes are emitted literally.
//   An accepted request passes from the input register through the decode
//   logic into the result group register. A request makes 0 to 3 results;
//   results leave one per cycle from the result group register while
//   res_ready is high. Requests that make at most one result stream at one per
//   cycle while res_ready is high; the input register takes a new
//   request while a result waits.
//   Requests that produce no result pass the decode stage without waiting.
//   When the receiver stalls, the result group holds, the input register fills
//   and req_ready drops; nothing is lost.
//   Reset (rst_n low, asynchronous) empties both stages and clears any pending
//   escape. end_of_text flushes pending bytes and returns to the idle phase.
module percent_escape_decoder_unit
    import ped_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] char_out,
    output logic       final_out
);

    // Input register
    logic   in_valid_reg;
    byte_t  char_reg;
    logic   eot_reg;

    // Escape state
    phase_t phase_reg, phase_next;
    byte_t  held_reg, held_next;

    // Result group register
    byte_t    grp_byte_reg [MAX_RES];
    res_cnt_t grp_cnt_reg;
    res_cnt_t grp_idx_reg;
    logic     grp_final_reg;

    // Decode outputs
    byte_t    res_byte [MAX_RES];
    res_cnt_t res_cnt;

    logic grp_last;
    logic grp_free;
    logic advance;

    // Decode one byte against the pending escape
    always_comb
    begin
        res_byte[0] = 8'd0;
        res_byte[1] = 8'd0;
        res_byte[2] = 8'd0;
        res_cnt     = 2'd0;
        phase_next  = phase_reg;
        held_next   = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (char_reg == PCT_CHAR)
                begin
                    res_byte[0] = PCT_CHAR;
                    res_cnt     = 2'd1;
                end
                else if (is_hex(char_reg))
                begin
                    held_next  = char_reg;
                    phase_next = PH_DIG;
                end
                else
                begin
                    res_byte[0] = PCT_CHAR;
                    res_byte[1] = char_reg;
                    res_cnt     = 2'd2;
                    phase_next  = PH_IDLE;
                end
            end
            PH_DIG:
            begin
                if (is_hex(char_reg))
                begin
                    res_byte[0] = {hex_nibble(held_reg), hex_nibble(char_reg)};
                    res_cnt     = 2'd1;
                    phase_next  = PH_IDLE;
                end
                else if (char_reg == PCT_CHAR)
                begin
                    res_byte[0] = PCT_CHAR;
                    res_byte[1] = held_reg;
                    res_cnt     = 2'd2;
                    phase_next  = PH_PCT;
                end
                else
                begin
                    res_byte[0] = PCT_CHAR;
                    res_byte[1] = held_reg;
                    res_byte[2] = char_reg;
                    res_cnt     = 2'd3;
                    phase_next  = PH_IDLE;
                end
            end
            default:
            begin
                if (char_reg == PCT_CHAR)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    res_byte[0] = char_reg;
                    res_cnt     = 2'd1;
                    phase_next  = PH_IDLE;
                end
            end
        endcase

        // End of text: flush whatever escape is still pending
        if (eot_reg)
        begin
            if (phase_next == PH_PCT)
            begin
                case (res_cnt)
                    2'd0:    res_byte[0] = PCT_CHAR;
                    2'd1:    res_byte[1] = PCT_CHAR;
                    default: res_byte[2] = PCT_CHAR;
                endcase
                res_cnt = res_cnt + 2'd1;
            end
            else if (phase_next == PH_DIG)
            begin
                // only reached from a held percent and a new digit: no results yet
                res_byte[0] = PCT_CHAR;
                res_byte[1] = held_next;
                res_cnt     = 2'd2;
            end
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    // Handshake and stage advance
    assign grp_last  = (grp_idx_reg == (grp_cnt_reg - 2'd1));
    assign grp_free  = (grp_cnt_reg == 2'd0) || (res_ready && grp_last);
    assign advance   = in_valid_reg && ((res_cnt == 2'd0) || grp_free);
    assign req_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            char_reg <= char_in;
            eot_reg  <= end_of_text;
        end
    end

    // Escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Result group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg   <= 2'd0;
            grp_idx_reg   <= 2'd0;
            grp_final_reg <= 1'b0;
        end
        else if (advance && (res_cnt != 2'd0))
        begin
            grp_cnt_reg   <= res_cnt;
            grp_idx_reg   <= 2'd0;
            grp_final_reg <= eot_reg;
        end
        else if (res_valid && res_ready)
        begin
            if (grp_last)
            begin
                grp_cnt_reg <= 2'd0;
                grp_idx_reg <= 2'd0;
            end
            else
            begin
                grp_idx_reg <= grp_idx_reg + 2'd1;
            end
        end
    end

    // Result group payload
    always_ff @(posedge clk)
    begin
        if (advance && (res_cnt != 2'd0))
        begin
            grp_byte_reg[0] <= res_byte[0];
            grp_byte_reg[1] <= res_byte[1];
            grp_byte_reg[2] <= res_byte[2];
        end
    end

    // Output select
    always_comb
    begin
        case (grp_idx_reg)
            2'd0:    char_out = grp_byte_reg[0];
            2'd1:    char_out = grp_byte_reg[1];
            default: char_out = grp_byte_reg[2];
        endcase
    end

    assign res_valid = (grp_cnt_reg != 2'd0);
    assign final_out = grp_final_reg && grp_last;

    // Checks
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_cnt_reg == 2'd0) || (grp_idx_reg < grp_cnt_reg))
        else $error("result index beyond group count");

    a_eot_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eot_reg) |=> (phase_reg == PH_IDLE) && (held_reg == 8'd0))
        else $error("end of text left an escape pending");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(char_reg)
            && $stable(eot_reg))
        else $error("stalled request lost from input register");

    a_held_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIG) |-> is_hex(held_reg))
        else $error("held digit is not a hex digit");

    a_group_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_cnt != 2'd0)) |=> res_valid)
        else $error("decoded results not presented");

endmodule
